FILE: rtl/ucl_pkg.sv
package ucl_pkg;

  // Line buffer limits
  localparam int unsigned LINE_CAPACITY = 64;
  localparam int unsigned LEN_W         = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);

  // Keyword set
  localparam int unsigned KW_COUNT = 9;
  localparam int unsigned KW_IDX_W = $clog2(KW_COUNT);
  localparam int unsigned POS_W    = 4;

  // Special characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Result event codes
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_CMD      = 3'd1,
    EV_COMMENT  = 3'd2,
    EV_UNKNOWN  = 3'd3,
    EV_OVERFLOW = 3'd4
  } event_t;

  // Position relative to the first word of the line
  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_IN     = 2'd1,
    PH_AFTER  = 2'd2
  } phase_t;

  // Keyword length
  function automatic logic [POS_W-1:0] kw_len(input logic [KW_IDX_W-1:0] k);
    logic [POS_W-1:0] len;
    case (k)
      4'd0:    len = 4'd5;  // TEMP?
      4'd1:    len = 4'd5;  // PRES?
      4'd2:    len = 4'd4;  // HUM?
      4'd3:    len = 4'd5;  // HELP?
      4'd4:    len = 4'd4;  // MENU
      4'd5:    len = 4'd6;  // REBOOT
      4'd6:    len = 4'd7;  // RESTART
      4'd7:    len = 4'd5;  // BAUD?
      4'd8:    len = 4'd4;  // I2C?
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // Character p of keyword k, zero past its end
  function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] k,
                                         input logic [2:0] p);
    logic [55:0] txt;
    logic [POS_W-1:0] len;
    int idx;
    case (k)
      4'd0:    txt = 56'("TEMP?");
      4'd1:    txt = 56'("PRES?");
      4'd2:    txt = 56'("HUM?");
      4'd3:    txt = 56'("HELP?");
      4'd4:    txt = 56'("MENU");
      4'd5:    txt = 56'("REBOOT");
      4'd6:    txt = 56'("RESTART");
      4'd7:    txt = 56'("BAUD?");
      4'd8:    txt = 56'("I2C?");
      default: txt = '0;
    endcase
    len = kw_len(k);
    if ({1'b0, p} >= len) begin
      return 8'h00;
    end
    idx = 8 * (int'(len) - 1 - int'(p));
    return txt[idx +: 8];
  endfunction

endpackage

FILE: rtl/ucl_matcher.sv
module ucl_matcher
  import ucl_pkg::*;
(
  input  logic [7:0]          ch,
  input  logic [POS_W-1:0]    pos,
  input  logic [KW_COUNT-1:0] cand,
  output logic [KW_COUNT-1:0] cand_next
);

  logic [7:0] up;

  // Fold a-z to upper case only
  always_comb begin
    up = ch;
    if (ch inside {[8'h61:8'h7A]}) begin
      up = ch - 8'h20;
    end
  end

  // Drop every keyword that disagrees at this position
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      cand_next[k] = cand[k] && (pos < kw_len(KW_IDX_W'(k))) &&
                     (kw_char(KW_IDX_W'(k), pos[2:0]) == up);
    end
  end

endmodule

FILE: rtl/ucl_classifier.sv
module ucl_classifier
  import ucl_pkg::*;
(
  input  logic [7:0]          first_ch,
  input  logic [7:0]          second_ch,
  input  logic                has_second,
  input  phase_t              phase,
  input  logic [POS_W-1:0]    pos,
  input  logic [KW_COUNT-1:0] cand,
  output event_t              ev,
  output logic [3:0]          cmd
);

  logic [KW_COUNT-1:0] hit;
  logic                found;
  logic [3:0]          hit_idx;

  // Keywords that survived and were matched to their full length
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      hit[k] = cand[k] && (kw_len(KW_IDX_W'(k)) == pos);
    end
  end

  // Lowest matching keyword wins
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) begin
        found   = 1'b1;
        hit_idx = 4'(k);
      end
    end
  end

  // Line classification at the terminator
  always_comb begin
    ev  = EV_NONE;
    cmd = '0;
    if (first_ch == CH_HASH ||
        (first_ch == CH_SLASH && has_second && second_ch == CH_SLASH)) begin
      ev = EV_COMMENT;
    end else if (phase != PH_BEFORE) begin
      if (found) begin
        ev  = EV_CMD;
        cmd = hit_idx;
      end else begin
        ev = EV_UNKNOWN;
      end
    end
  end

endmodule

FILE: rtl/uart_command_line_parser.sv
// UART command line parser.
// Input stream: s_tdata carries one received byte per transfer. Output
// stream: one transfer per input byte, holding the echoed byte, an event
// code and a command code. An event is raised on CR or LF closing a
// non-blank line (command, comment or unknown), or when a byte arrives at
// a full line (overflow, the line is discarded and the byte dropped).
// Only the first two characters and a running match of the first word
// against the nine keywords are kept, so no line buffer exists.
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one byte per cycle while the output is not stalled; the per-byte state update and the
// keyword compare sit between the input handshake and the output register.
// s_tready is high while the output register is empty or being drained, so
// a stalled receiver holds the pending result and back-pressures the input
// after one item.
// Reset (rst, synchronous) empties the output register and starts a new,
// empty line with all keywords as candidates.
module uart_command_line_parser
  import ucl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] echo_byte, [10:8] event_res, [14:11] command, [15] 0
);

  // Line state
  logic [LEN_W-1:0]    line_length, line_length_next;
  logic [7:0]          first_ch, first_ch_next;
  logic [7:0]          second_ch, second_ch_next;
  phase_t              phase, phase_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [KW_COUNT-1:0] cand, cand_next;

  // Output register
  logic [7:0]          echo_q;
  event_t              ev_q, ev_next;
  logic [3:0]          cmd_q, cmd_next;

  logic                in_xfer;
  logic                is_term;
  logic [KW_COUNT-1:0] cand_match;
  event_t              cls_ev;
  logic [3:0]          cls_cmd;

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;
  assign is_term  = (s_tdata == CH_CR) || (s_tdata == CH_LF);

  ucl_matcher u_matcher (
    .ch        (s_tdata),
    .pos       (pos),
    .cand      (cand),
    .cand_next (cand_match)
  );

  ucl_classifier u_classifier (
    .first_ch   (first_ch),
    .second_ch  (second_ch),
    .has_second (line_length >= LEN_W'(2)),
    .phase      (phase),
    .pos        (pos),
    .cand       (cand),
    .ev         (cls_ev),
    .cmd        (cls_cmd)
  );

  // Per-byte line update
  always_comb begin
    line_length_next = line_length;
    first_ch_next    = first_ch;
    second_ch_next   = second_ch;
    phase_next       = phase;
    pos_next         = pos;
    cand_next        = cand;
    ev_next          = EV_NONE;
    cmd_next         = '0;
    if (is_term) begin
      if (line_length != '0) begin
        ev_next          = cls_ev;
        cmd_next         = cls_cmd;
        line_length_next = '0;
        first_ch_next    = '0;
        second_ch_next   = '0;
        phase_next       = PH_BEFORE;
        pos_next         = '0;
        cand_next        = '1;
      end
    end else if (line_length == LEN_LAST) begin
      ev_next          = EV_OVERFLOW;
      line_length_next = '0;
      first_ch_next    = '0;
      second_ch_next   = '0;
      phase_next       = PH_BEFORE;
      pos_next         = '0;
      cand_next        = '1;
    end else begin
      if (line_length == '0) begin
        first_ch_next  = s_tdata;
        second_ch_next = '0;
      end else if (line_length == LEN_W'(1)) begin
        second_ch_next = s_tdata;
      end
      line_length_next = line_length + LEN_W'(1);
      if (s_tdata == CH_SPACE) begin
        if (phase == PH_IN) begin
          phase_next = PH_AFTER;
        end
      end else if (phase != PH_AFTER) begin
        phase_next = PH_IN;
        cand_next  = cand_match;
        if (pos != '1) begin
          pos_next = pos + POS_W'(1);
        end
      end
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      first_ch    <= '0;
      second_ch   <= '0;
      phase       <= PH_BEFORE;
      pos         <= '0;
      cand        <= '1;
      m_tvalid    <= 1'b0;
    end else begin
      if (in_xfer) begin
        line_length <= line_length_next;
        first_ch    <= first_ch_next;
        second_ch   <= second_ch_next;
        phase       <= phase_next;
        pos         <= pos_next;
        cand        <= cand_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      echo_q <= s_tdata;
      ev_q   <= ev_next;
      cmd_q  <= cmd_next;
    end
  end

  assign m_tdata = {1'b0, cmd_q, ev_q, echo_q};

  // Every accepted byte shows up as the echo in the next cycle
  a_echo: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (m_tvalid && m_tdata[7:0] == $past(s_tdata)))
    else $error("echo does not follow accepted byte");

  // Command code only accompanies a recognized command
  a_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (ev_q != EV_CMD) |-> (cmd_q == '0))
    else $error("command code set without command event");

  // Line never grows past capacity minus one
  a_len: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_LAST)
    else $error("line length beyond capacity");

  // Terminator always leaves an empty line behind
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    in_xfer && is_term |=> (line_length == '0 && cand == '1))
    else $error("line state not cleared after terminator");

endmodule
